/* sv/hsfc_pkg.sv */
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types, constants and conversion functions for the half/single
// format converter.
// ----------------------------------------------------------------------------
`default_nettype none
package hsfc_pkg;

    localparam int unsigned ValueW  = 32;
    localparam int unsigned ResultW = 32;

    typedef enum logic {
        KIND_H2S = 1'b0,
        KIND_S2H = 1'b1
    } t_kind;

    typedef struct packed {
        logic              kind;
        logic [ValueW-1:0] value;
    } t_req;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic        sgn;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  n;
        logic [9:0]  nm;
        logic [7:0]  sex;
        logic [31:0] res;
        sgn = h[15];
        ex  = h[14:10];
        man = h[9:0];
        n   = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                n = 4'(10 - i);
            end
        end
        nm  = 10'(man << n);
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                res = {sgn, 31'd0};
            end else begin
                sex = 8'(8'd113 - {4'd0, n});
                res = {sgn, sex, nm, 13'd0};
            end
        end else if (ex == 5'h1F) begin
            res = {sgn, 8'hFF, man, 13'd0};
        end else begin
            sex = 8'({3'd0, ex} + 8'd112);
            res = {sgn, sex, man, 13'd0};
        end
        return res;
    endfunction

    function automatic logic [15:0] single_to_half(input logic [31:0] f);
        logic        sgn;
        logic [7:0]  bex;
        logic [22:0] man;
        logic [23:0] fm;
        logic [4:0]  sh;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] hlf;
        logic [15:0] r;
        logic [15:0] res;
        sgn = f[31];
        bex = f[30:23];
        man = f[22:0];
        fm  = {1'b1, man};
        sh  = 5'(9'd126 - {1'b0, bex});
        q   = fm >> sh;
        hlf = 24'd1 << (sh - 5'd1);
        rem = fm & ((24'd1 << sh) - 24'd1);
        r   = {sgn, 5'(bex - 8'd112), man[22:13]};
        if (bex == 8'hFF) begin
            res = {sgn, 5'h1F, (man != 23'd0), 9'd0};
        end else if (bex >= 8'd143) begin
            res = {sgn, 5'h1F, 10'd0};
        end else if (bex <= 8'd112) begin
            if (bex < 8'd102) begin
                res = {sgn, 15'd0};
            end else begin
                if (rem > hlf || (rem == hlf && q[0])) begin
                    q = q + 24'd1;
                end
                res = {sgn, q[14:0]};
            end
        end else begin
            if (man[12:0] > 13'h1000 || (man[12:0] == 13'h1000 && r[0])) begin
                r = r + 16'd1;
            end
            res = r;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* sv/hsfc_if.sv */
// ----------------------------------------------------------------------------
// hsfc_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`default_nettype none
interface hsfc_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/hsfc_core.sv */
// ----------------------------------------------------------------------------
// hsfc_core
// Combinational format conversion between input and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module hsfc_core
    import hsfc_pkg::*;
(
    input  wire t_req               i_req,
    output logic [ResultW-1:0]      o_result
);
    always_comb begin
        if (i_req.kind == KIND_H2S) begin
            o_result = half_to_single(i_req.value[15:0]);
        end else begin
            o_result = {16'd0, single_to_half(i_req.value)};
        end
    end
endmodule
`default_nettype wire

/* sv/half_single_float_convert_top.sv */
// ----------------------------------------------------------------------------
// half_single_float_convert_top
// IEEE half <-> single precision converter, one item per cycle unless stalled.
//
// Usage: i_req carries kind (0 half to single, 1 single to half) and value.
// o_rsp carries result; half results sit in bits 15..0, upper bits zero.
// An input item is registered on acceptance; the conversion is bit logic
// between that input register and the result register, from which the
// result leaves. Throughput is one item per cycle while the receiver is
// ready, set by the two-stage register pipeline. Each stage advances
// when the stage after it is empty or being drained, so a receiver stall
// holds the result stage, holds the input stage too once it is full, and
// drops i_req.ready only when both are full and the receiver stalls.
// Reset clears both valid flags; no item is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none
module half_single_float_convert_top
    import hsfc_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    hsfc_if.sink          i_req,
    hsfc_if.source        o_rsp
);
    logic               r_in_vld;
    t_req               r_in;
    logic               r_out_vld;
    logic [ResultW-1:0] r_out;
    logic [ResultW-1:0] n_out;
    logic               w_out_adv;
    logic               w_in_adv;

    hsfc_core u_core (
        .i_req    (r_in),
        .o_result (n_out)
    );

    assign w_out_adv   = !r_out_vld || o_rsp.ready;
    assign w_in_adv    = !r_in_vld || w_out_adv;
    assign i_req.ready = w_in_adv;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_adv) begin
                r_in_vld <= i_req.valid;
            end
            if (w_out_adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_adv && i_req.valid) begin
            r_in <= i_req.data;
        end
        if (w_out_adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_rsp.ready |=> r_out_vld && $stable(r_out))
        else $error("result lost under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> r_in_vld && r_out_vld)
        else $error("ready low with free stage");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && w_out_adv |=> r_out_vld)
        else $error("item dropped between stages");
    a_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && w_out_adv && r_in.kind == KIND_S2H |=> r_out[31:16] == 16'd0)
        else $error("half result upper bits set");
`endif

endmodule
`default_nettype wire

/* tb/tb_half_single_float_convert_top.sv */
// ----------------------------------------------------------------------------
// tb_half_single_float_convert_top
// Half/single float conversion test: directed corner values in both
// directions, then random items; random gaps and receiver stalls until
// the last items; results checked against a bit-level conversion predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_half_single_float_convert_top;
    import hsfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;

    hsfc_if #(.T(t_req))        req_if ();
    hsfc_if #(.T(logic [31:0])) rsp_if ();

    half_single_float_convert_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    logic [31:0] expected_q[$];
    int unsigned mismatches;
    bit          idle_on;
    bit          send_done;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  ex;
        logic [10:0] man;
        int          n;
        sgn = {h[15], 31'd0};
        ex  = h[14:10];
        man = {1'b0, h[9:0]};
        n   = 0;
        if (ex == 5'd0) begin
            if (man == 11'd0) return sgn;
            while (!man[10]) begin
                man = man << 1;
                n++;
            end
            return sgn | (32'(113 - n) << 23) | (32'(man[9:0]) << 13);
        end
        if (ex == 5'h1F) return sgn | 32'h7F80_0000 | (32'(man[9:0]) << 13);
        return sgn | (32'(ex + 112) << 23) | (32'(man[9:0]) << 13);
    endfunction

    function automatic logic [31:0] narrow_single(input logic [31:0] f);
        logic [31:0] sgn;
        logic [31:0] man;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] hlf;
        logic [31:0] r;
        int          ex;
        int          sh;
        sgn = {16'd0, f[31], 15'd0};
        man = {9'd0, f[22:0]};
        ex  = int'(f[30:23]) - 112;
        if (f[30:23] == 8'hFF) return sgn | 32'h7C00 | (man != 0 ? 32'h200 : 32'h0);
        if (ex >= 31) return sgn | 32'h7C00;
        if (ex <= 0) begin
            if (ex < -10) return sgn;
            man = man | 32'h80_0000;
            sh  = 14 - ex;
            q   = man >> sh;
            rem = man & ((32'd1 << sh) - 1);
            hlf = 32'd1 << (sh - 1);
            if (rem > hlf || (rem == hlf && q[0])) q++;
            return sgn | q;
        end
        r   = sgn | (32'(ex) << 10) | (man >> 13);
        rem = man & 32'h1FFF;
        if (rem > 32'h1000 || (rem == 32'h1000 && r[0])) r++;
        return r & 32'hFFFF;
    endfunction

    task automatic send_item(input t_kind kind, input logic [31:0] value);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.data.kind  <= kind;
        req_if.data.value <= value;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_q.push_back(kind == KIND_H2S ? widen_half(value[15:0])
                                              : narrow_single(value));
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", rsp_if.data);
            end else begin
                if (rsp_if.data !== expected_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result exp %h got %h", expected_q[0], rsp_if.data);
                end
                void'(expected_q.pop_front());
            end
        end
    end

    initial begin
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        while (!send_done) begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic test_half_corners();
        logic [15:0] h[] = '{16'h0000, 16'h8000, 16'h0001, 16'h8001, 16'h03FF, 16'h0200,
                             16'h0400, 16'h7BFF, 16'h7C00, 16'hFC00, 16'h7C01, 16'h7E00,
                             16'hFFFF, 16'h3C00};
        foreach (h[i]) send_item(KIND_H2S, {16'($urandom_range(0, 65535)), h[i]});
    endtask

    task automatic test_single_corners();
        logic [31:0] f[] = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h3380_0000,
                             32'h3380_0001, 32'h33C0_0000, 32'h387F_E000, 32'h387F_F000,
                             32'h3880_0000, 32'h477F_E000, 32'h477F_F000, 32'h4780_0000,
                             32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0001, 32'hFFFF_FFFF,
                             32'h3F80_1000, 32'h3F80_3000, 32'h3F80_1001, 32'h7F7F_FFFF};
        foreach (f[i]) send_item(KIND_S2H, f[i]);
    endtask

    task automatic test_random(input int count);
        logic [31:0] v;
        for (int i = 0; i < count; i++) begin
            v = $urandom();
            if ($urandom_range(0, 1)) v[30:23] = 8'($urandom_range(98, 146));
            if ($urandom_range(0, 3) == 0) v[12:0] = {1'b1, 12'd0};
            if (i > count - 100) idle_on = 1'b0;
            send_item($urandom_range(0, 1) ? KIND_S2H : KIND_H2S, v);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        mismatches   = 0;
        idle_on      = 1'b1;
        send_done    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_half_corners();
        test_single_corners();
        test_random(900);
        req_if.valid <= 1'b0;
        send_done = 1'b1;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) $display("half_single_float_convert_top: match");
        else $display("half_single_float_convert_top: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("half_single_float_convert_top: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

/* half_single_float_convert_top.f */
sv/hsfc_pkg.sv
sv/hsfc_if.sv
sv/hsfc_core.sv
sv/half_single_float_convert_top.sv
tb/tb_half_single_float_convert_top.sv
